### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define FCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define FCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int MAX_RADIUS = 1024;

  // fixed field widths
  localparam int FX_W      = 16;
  localparam int RFX_W     = 14;
  localparam int COLOR_W   = 32;
  localparam int IDX_W     = 24;
  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 1;

  // internal widths
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int RAD_W   = $clog2(MAX_RADIUS) + 1;
  localparam int OFS_W   = RAD_W + 1;
  localparam int PT_W    = 13;
  localparam int R2_W    = 20;
  localparam int SQ_W    = 2 * RAD_W - 1;

  // queue between front and back
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  // mask bit order: x0y0, x0y1, x1y0, x1y1
  typedef struct packed {
    logic [3:0]         mask;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [IDX_W-1:0]   yw0;
    logic [IDX_W-1:0]   yw1;
    logic [COLOR_W-1:0] color;
    logic               busy;
  } entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } qstat_t;

endpackage

`default_nettype wire

### src/fcr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_front
  import fcr_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  input  wire cfg_t                cfg,
  input  wire                      item_valid,
  output logic                     item_stall,
  input  wire                      kind,
  input  wire logic signed [FX_W-1:0] centre_x_fx,
  input  wire logic signed [FX_W-1:0] centre_y_fx,
  input  wire [RFX_W-1:0]          radius_fx,
  input  wire [COLOR_W-1:0]        fill_color,
  input  wire qstat_t              qstat,
  output logic                     push,
  output entry_t                   push_entry
);

  function automatic logic signed [PT_W-1:0] round_fx(input logic signed [FX_W-1:0] v);
    logic signed [FX_W:0] s;
    logic signed [FX_W:0] t;
    s = {v[FX_W-1], v} + (FX_W+1)'(8);
    t = s + (s[FX_W] ? (FX_W+1)'(15) : (FX_W+1)'(0));
    round_fx = PT_W'(t >>> 4);
  endfunction

  // circle state
  logic [COLOR_W-1:0]     circle_color, circle_color_next;
  logic signed [PT_W-1:0] ctr_x, ctr_x_next;
  logic signed [PT_W-1:0] ctr_y, ctr_y_next;
  logic [RAD_W-1:0]       radius_int, radius_int_next;
  logic [R2_W-1:0]        radius_squared, radius_squared_next;
  logic [RAD_W-1:0]       outer_offset, outer_offset_next;
  logic [RAD_W-1:0]       inner_offset, inner_offset_next;
  logic                   active, active_next;

  // stage 1
  logic                    s1_v, s1_step, s1_busy;
  logic signed [OFS_W-1:0] s1_i, s1_j;
  logic [COORD_W-1:0]      s1_x0, s1_x1, s1_y0, s1_y1;
  logic [3:0]              s1_clip;
  logic [DIM_W-1:0]        s1_w;
  logic [R2_W-1:0]         s1_r2;
  logic [COLOR_W-1:0]      s1_color;

  // stage 2
  logic               s2_v, s2_step, s2_busy;
  logic [SQ_W-1:0]    s2_ii, s2_jj;
  logic [COORD_W-1:0] s2_x0, s2_x1;
  logic [IDX_W-1:0]   s2_yw0, s2_yw1;
  logic [3:0]         s2_clip;
  logic [R2_W-1:0]    s2_r2;
  logic [COLOR_W-1:0] s2_color;

  logic [QCNT_W:0] pending;
  logic            accept;

  // credit check: everything in flight must find a queue slot
  assign pending = {1'b0, qstat.count} + (QCNT_W+1)'(s1_v) + (QCNT_W+1)'(s2_v);
  assign item_stall = pending >= (QCNT_W+1)'(QDEPTH);
  assign accept = item_valid && !item_stall;

  logic [RFX_W:0]          rsum;
  logic [RAD_W-1:0]        r_raw, r_new;
  logic [2*RFX_W-1:0]      rsq;
  logic [2*RFX_W:0]        rsq_rnd;
  logic signed [OFS_W-1:0] pt_i, pt_j;
  logic signed [PT_W-1:0]  ie, je, x0, x1, y0, y1;
  logic [DIM_W-1:0]        w_eff, h_eff;
  logic [3:0]              clip;
  logic                    is_step;

  always_comb begin
    rsum    = {1'b0, radius_fx} + (RFX_W+1)'(8);
    r_raw   = rsum[RFX_W:4];
    r_new   = (r_raw > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_raw;
    rsq     = radius_fx * radius_fx;
    rsq_rnd = {1'b0, rsq} + (2*RFX_W+1)'(128);

    pt_i = $signed({1'b0, outer_offset}) - $signed({1'b0, radius_int});
    pt_j = $signed({1'b0, inner_offset}) - $signed({1'b0, radius_int});
    ie   = PT_W'(pt_i);
    je   = PT_W'(pt_j);
    x0   = ctr_x + ie;
    x1   = ctr_x - ie;
    y0   = ctr_y + je;
    y1   = ctr_y - je;

    w_eff = (cfg.width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.width;
    h_eff = (cfg.height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.height;
    clip[0] = !x0[PT_W-1] && ($unsigned(x0) < w_eff);
    clip[1] = !x1[PT_W-1] && ($unsigned(x1) < w_eff);
    clip[2] = !y0[PT_W-1] && ($unsigned(y0) < h_eff);
    clip[3] = !y1[PT_W-1] && ($unsigned(y1) < h_eff);

    circle_color_next   = circle_color;
    ctr_x_next          = ctr_x;
    ctr_y_next          = ctr_y;
    radius_int_next     = radius_int;
    radius_squared_next = radius_squared;
    outer_offset_next   = outer_offset;
    inner_offset_next   = inner_offset;
    active_next         = active;
    is_step             = 1'b0;

    if (accept) begin
      if (kind == KIND_START) begin
        circle_color_next   = fill_color;
        ctr_x_next          = round_fx(centre_x_fx);
        ctr_y_next          = round_fx(centre_y_fx);
        radius_int_next     = r_new;
        radius_squared_next = rsq_rnd[R2_W+7:8];
        outer_offset_next   = '0;
        inner_offset_next   = '0;
        active_next         = 1'b1;
      end else if (active) begin
        is_step = 1'b1;
        if (inner_offset < radius_int) begin
          inner_offset_next = inner_offset + RAD_W'(1);
        end else begin
          inner_offset_next = '0;
          if (outer_offset < radius_int) begin
            outer_offset_next = outer_offset + RAD_W'(1);
          end else begin
            active_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      circle_color   <= '0;
      ctr_x          <= '0;
      ctr_y          <= '0;
      radius_int     <= '0;
      radius_squared <= '0;
      outer_offset   <= '0;
      inner_offset   <= '0;
      active         <= 1'b0;
      s1_v           <= 1'b0;
      s2_v           <= 1'b0;
    end else begin
      circle_color   <= circle_color_next;
      ctr_x          <= ctr_x_next;
      ctr_y          <= ctr_y_next;
      radius_int     <= radius_int_next;
      radius_squared <= radius_squared_next;
      outer_offset   <= outer_offset_next;
      inner_offset   <= inner_offset_next;
      active         <= active_next;
      s1_v           <= accept;
      s2_v           <= s1_v;
    end
  end

  logic signed [2*OFS_W-1:0]  ii_full, jj_full;
  logic [COORD_W+DIM_W-1:0]   yw0_full, yw1_full;

  assign ii_full  = s1_i * s1_i;
  assign jj_full  = s1_j * s1_j;
  assign yw0_full = s1_y0 * s1_w;
  assign yw1_full = s1_y1 * s1_w;

  // payload pipeline, no reset needed
  always_ff @(posedge clk) begin
    s1_step  <= is_step;
    s1_busy  <= active_next;
    s1_i     <= pt_i;
    s1_j     <= pt_j;
    s1_x0    <= COORD_W'(x0);
    s1_x1    <= COORD_W'(x1);
    s1_y0    <= COORD_W'(y0);
    s1_y1    <= COORD_W'(y1);
    s1_clip  <= clip;
    s1_w     <= w_eff;
    s1_r2    <= radius_squared;
    s1_color <= circle_color;

    s2_step  <= s1_step;
    s2_busy  <= s1_busy;
    s2_ii    <= ii_full[SQ_W-1:0];
    s2_jj    <= jj_full[SQ_W-1:0];
    s2_x0    <= s1_x0;
    s2_x1    <= s1_x1;
    s2_yw0   <= yw0_full[IDX_W-1:0];
    s2_yw1   <= yw1_full[IDX_W-1:0];
    s2_clip  <= s1_clip;
    s2_r2    <= s1_r2;
    s2_color <= s1_color;
  end

  logic [SQ_W:0] pt_dist;
  logic          in_circle;

  always_comb begin
    pt_dist   = {1'b0, s2_ii} + {1'b0, s2_jj};
    in_circle = s2_step && (pt_dist <= (SQ_W+1)'(s2_r2));
    push      = s2_v;
    push_entry.mask  = in_circle ? {s2_clip[1] & s2_clip[3], s2_clip[1] & s2_clip[2],
                                    s2_clip[0] & s2_clip[3], s2_clip[0] & s2_clip[2]}
                                 : 4'b0000;
    push_entry.x0    = s2_x0;
    push_entry.x1    = s2_x1;
    push_entry.yw0   = s2_yw0;
    push_entry.yw1   = s2_yw1;
    push_entry.color = s2_color;
    push_entry.busy  = s2_busy;
  end

endmodule

`default_nettype wire

### src/fcr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_queue
  import fcr_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  input  wire entry_t push_entry,
  input  wire         pop,
  output entry_t      head,
  output qstat_t      qstat
);

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  assign head        = slots[rptr];
  assign qstat.count = count;
  assign qstat.empty = (count == '0);

endmodule

`default_nettype wire

### src/fcr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_back
  import fcr_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire entry_t        head,
  input  wire qstat_t        qstat,
  output logic               pop,
  output logic               res_valid,
  input  wire                res_stall,
  output logic               write_enable,
  output logic [IDX_W-1:0]   pixel_index,
  output logic [COLOR_W-1:0] pixel_value,
  output logic               last,
  output logic               busy_res
);

  logic [3:0]         done_mask;
  logic [3:0]         rem, sel;
  logic               final_beat, load, wr;
  logic [COORD_W-1:0] x_sel;
  logic [IDX_W-1:0]   yw_sel;

  always_comb begin
    rem        = head.mask & ~done_mask;
    sel        = rem & (~rem + 4'd1);
    final_beat = (rem & ~sel) == 4'b0000;
    wr         = rem != 4'b0000;
    load       = !qstat.empty && (!res_valid || !res_stall);
    pop        = load && final_beat;
    x_sel      = (sel[2] || sel[3]) ? head.x1 : head.x0;
    yw_sel     = (sel[1] || sel[3]) ? head.yw1 : head.yw0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_mask <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        done_mask <= final_beat ? 4'b0000 : (done_mask | sel);
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      write_enable <= wr;
      pixel_index  <= wr ? (IDX_W'(x_sel) + yw_sel) : '0;
      pixel_value  <= wr ? head.color : '0;
      last         <= final_beat;
      busy_res     <= head.busy;
    end
  end

endmodule

`default_nettype wire

### src/filled_circle_rasterizer_top.sv
// an accepted item passes stage 1, stage 2, the queue and the output register before its first result beat
// throughput: one item accepted per cycle while the 8-entry queue has room
// each item yields one result beat per cycle at the output while res_stall is low, up to 4 beats per step
// so a step with k pixel writes yields max(k,1) beats
// reset: synchronous, circle state idle and zero, width 640, height 480, queue empty
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module filled_circle_rasterizer_top
  import fcr_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  // item channel
  input  wire                      item_valid,
  output logic                     item_stall,
  input  wire                      kind,
  input  wire logic signed [FX_W-1:0] centre_x_fx,
  input  wire logic signed [FX_W-1:0] centre_y_fx,
  input  wire [RFX_W-1:0]          radius_fx,
  input  wire [COLOR_W-1:0]        fill_color,
  // result channel
  output logic                     res_valid,
  input  wire                      res_stall,
  output logic                     write_enable,
  output logic [IDX_W-1:0]         pixel_index,
  output logic [COLOR_W-1:0]       pixel_value,
  output logic                     last,
  output logic                     busy_res,
  // configuration write channel
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire [CFG_IDX_W-1:0]      cfg_index,
  input  wire [DIM_W-1:0]          cfg_data
);

  // frame buffer geometry, to be written by the user only while idle; the block itself does not enforce this
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= DIM_W'(640);
      cfg.height <= DIM_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  cfg.width  <= cfg_data;
        CFG_HEIGHT: cfg.height <= cfg_data;
        default:    cfg.width  <= cfg.width;
      endcase
    end
  end

  // front to queue, queue to back
  logic   q_push, q_pop;
  entry_t q_in, q_head;
  qstat_t qstat;

  // front: loads circles, walks the quadrant, squares and compares,
  // clips the four mirrored points and forms row offsets y*width
  fcr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .kind        (kind),
    .centre_x_fx (centre_x_fx),
    .centre_y_fx (centre_y_fx),
    .radius_fx   (radius_fx),
    .fill_color  (fill_color),
    .qstat       (qstat),
    .push        (q_push),
    .push_entry  (q_in)
  );

  // short queue so the front keeps taking items while writes drain
  fcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .qstat      (qstat)
  );

  // back: expands each entry into its pixel write beats, one per cycle while res_stall is low,
  // through the output register
  fcr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .qstat        (qstat),
    .pop          (q_pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .write_enable (write_enable),
    .pixel_index  (pixel_index),
    .pixel_value  (pixel_value),
    .last         (last),
    .busy_res     (busy_res)
  );

  // credits in the front must keep the queue from overflowing
  `FCR_ASSERT_IMP(a_queue_no_overflow, q_push && !q_pop, qstat.count < QCNT_W'(QDEPTH), "queue overflow")
  // the back end only drains a queue that holds something
  `FCR_ASSERT_IMP(a_pop_nonempty, q_pop, !qstat.empty, "pop from empty queue")
  // a beat without a write is always the only and final beat, with zero payload
  `FCR_ASSERT_IMP(a_nowrite_final, res_valid && !write_enable, last && pixel_index == '0 && pixel_value == '0, "no-write beat malformed")
  // a push without a pop leaves the queue occupied
  `FCR_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !qstat.empty, "push lost")

endmodule

`default_nettype wire
